/* design/alpha_fade_envelope_assert.svh */
// assertion macros shared by the fade envelope rtl
// depends on nothing; files that check their logic include it by name
`ifndef ALPHA_FADE_ENVELOPE_ASSERT_SVH
`define ALPHA_FADE_ENVELOPE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define AFE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alpha_fade_envelope check failed");

// next-cycle implication, disabled in reset
`define AFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alpha_fade_envelope check failed");

`endif

/* design/afe_pkg.sv */
// types, constants and codes for the fade envelope
// used by alpha_fade_envelope; depends on nothing
package afe_pkg;

  localparam int LEVEL_FRAC_BITS = 16;
  localparam int TIME_BITS       = 31;
  localparam int REG_W           = 16;
  localparam int REG_IDX_W       = 2;
  localparam int FUNC_W          = 2;

  localparam int LEVEL_W  = LEVEL_FRAC_BITS + 1;
  localparam int LEN_W    = REG_W + 1;
  localparam int PROD_W   = LEVEL_W + LEN_W;
  localparam int START_W  = TIME_BITS + 1;
  localparam int END_W    = TIME_BITS + 2;
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SHOW  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_HIDE  = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_IN_DELAY     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IN_DURATION  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUT_DELAY    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_DURATION = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic                 auto_back;
    logic                 instant;
    logic [TIME_BITS-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] alpha;
    logic               target_is_shown;
    logic               will_toggle_back;
    logic               resting_is_shown;
    logic               fade_complete;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_LEN,
    S_MUL,
    S_DIV,
    S_APPLY,
    S_OUT
  } fade_state_t;

endpackage

/* design/alpha_fade_envelope.sv */
// fade envelope: show/hide commands and timed alpha queries
// depends on afe_pkg and alpha_fade_envelope_assert.svh
//
//   port group   dir  what moves
//   in_*         in   one command or query item per accept
//   out_*        out  one result item for each input item
//   cfg_*        in   register write, index and 16-bit data
//
// commands and queries that need no ramp math: result in the cycle after accept
// ramp queries: worked by one shared 17x17 multiplier used twice
//   and a restoring divider that retires one quotient bit per cycle (34 bits)
// in_stall stays high while a ramp query is worked and while a result waits
// reset is synchronous; it restores the hidden, finished state with zero level
`include "alpha_fade_envelope_assert.svh"

module alpha_fade_envelope (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  afe_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output afe_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [afe_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [afe_pkg::REG_W-1:0]     cfg_wdata
);
  import afe_pkg::*;

  // configuration
  logic [REG_W-1:0] in_delay_ms, in_duration_ms, out_delay_ms, out_duration_ms;

  // envelope state
  logic                 target_shown, resting_shown, done_flag;
  logic [LEVEL_W-1:0]   level_now, level_at_change;
  logic [TIME_BITS-1:0] time_at_change, time_last_query;

  // sequencer and working registers
  fade_state_t          state, state_next;
  logic                 fade_in;
  logic [TIME_BITS-1:0] now_r;
  logic [START_W-1:0]   start_r;
  logic [LEVEL_W-1:0]   dist_r;
  logic [REG_W-1:0]     dur_r;
  logic [LEN_W-1:0]     len_r, elapsed_r;
  logic [PROD_W-1:0]    prod_r;
  logic [LEN_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [LEVEL_W-1:0]   alpha_r;

  // control outputs
  logic in_accept, out_free, out_load_idle, out_load_seq;

  // input decode
  logic is_cmd, want, fade_query;
  assign is_cmd     = (in_data.func == FUNC_SHOW) || (in_data.func == FUNC_HIDE);
  assign want       = (in_data.func == FUNC_SHOW);
  assign fade_query = !is_cmd && !done_flag && (time_last_query != in_data.now_ms);

  // ramp setup from current state
  logic [REG_W-1:0]   sel_delay;
  logic               skip_delay;
  logic [START_W-1:0] start_calc;
  assign sel_delay  = target_shown ? in_delay_ms : out_delay_ms;
  assign skip_delay = (sel_delay == '0) ||
                      (target_shown && (level_at_change != '0)) ||
                      (!target_shown && (level_at_change < LEVEL_ONE));
  assign start_calc = START_W'(time_at_change) +
                      (skip_delay ? START_W'(0) : START_W'(sel_delay));

  // shared multiplier: dist * duration, then dist * elapsed
  logic [LEN_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  assign mul_b = (state == S_START) ? LEN_W'(dur_r) : elapsed_r;
  assign mul_p = PROD_W'(dist_r) * PROD_W'(mul_b);

  // ramp length and end check
  logic [LEN_W-1:0]   len_calc;
  logic [END_W-1:0]   end_calc;
  logic               ramping;
  logic [START_W-1:0] elapsed_full;
  assign len_calc     = prod_r[LEVEL_FRAC_BITS +: LEN_W];
  assign end_calc     = END_W'(start_r) + END_W'(len_calc);
  assign ramping      = (dur_r != '0) && (len_calc != '0) && (END_W'(now_r) < end_calc);
  assign elapsed_full = START_W'(now_r) - start_r;

  logic before_start;
  assign before_start = START_W'(now_r) < start_r;

  // divider step
  logic [LEN_W:0] div_trial;
  logic           div_bit;
  assign div_trial = {rem_r, prod_r[PROD_W-1]};
  assign div_bit   = div_trial >= {1'b0, len_r};

  logic div_last;
  assign div_last = (div_cnt == DIV_CNT_W'(PROD_W - 1));

  logic [LEVEL_W-1:0] delta, level_ramp;
  assign delta      = prod_r[LEVEL_W-1:0];
  assign level_ramp = fade_in ? level_at_change + delta : level_at_change - delta;

  logic [LEVEL_W-1:0] target_level;
  assign target_level = fade_in ? LEVEL_ONE : '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept && fade_query) state_next = S_START;
      end
      S_START: begin
        state_next = before_start ? S_OUT : S_LEN;
      end
      S_LEN: begin
        state_next = ramping ? S_MUL : S_OUT;
      end
      S_MUL:   state_next = S_DIV;
      S_DIV: begin
        if (div_last) state_next = S_APPLY;
      end
      S_APPLY: state_next = S_OUT;
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    out_free      = !out_valid || !out_stall;
    in_stall      = (state != S_IDLE) || !out_free;
    in_accept     = in_valid && !in_stall;
    out_load_idle = in_accept && !fade_query;
    out_load_seq  = (state == S_OUT) && out_free;
  end

  // result of a command or a query that needs no ramp math
  out_item_t imm_item;
  always_comb begin
    imm_item = '0;
    if (is_cmd) begin
      imm_item.alpha            = in_data.instant ? (want ? LEVEL_ONE : '0) : level_now;
      imm_item.target_is_shown  = want;
      imm_item.resting_is_shown = in_data.auto_back ? resting_shown : want;
      imm_item.will_toggle_back = want != imm_item.resting_is_shown;
      imm_item.fade_complete    = in_data.instant;
    end else begin
      imm_item.alpha            = level_now;
      imm_item.target_is_shown  = target_shown;
      imm_item.resting_is_shown = resting_shown;
      imm_item.will_toggle_back = target_shown != resting_shown;
      imm_item.fade_complete    = done_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      in_delay_ms     <= '0;
      in_duration_ms  <= '0;
      out_delay_ms    <= '0;
      out_duration_ms <= '0;
      target_shown    <= 1'b0;
      resting_shown   <= 1'b0;
      done_flag       <= 1'b1;
      level_now       <= '0;
      level_at_change <= '0;
      time_at_change  <= '0;
      time_last_query <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_addr)
          REG_IN_DELAY:     in_delay_ms     <= cfg_wdata;
          REG_IN_DURATION:  in_duration_ms  <= cfg_wdata;
          REG_OUT_DELAY:    out_delay_ms    <= cfg_wdata;
          REG_OUT_DURATION: out_duration_ms <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_load_idle || out_load_seq) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // commands update the envelope at accept
      if (in_accept && is_cmd) begin
        target_shown <= want;
        if (!in_data.auto_back) resting_shown <= want;
        if (in_data.instant) begin
          level_at_change <= want ? LEVEL_ONE : '0;
          level_now       <= want ? LEVEL_ONE : '0;
          done_flag       <= 1'b1;
        end else begin
          level_at_change <= level_now;
          time_at_change  <= in_data.now_ms;
          done_flag       <= 1'b0;
        end
      end

      if (in_accept && fade_query) time_last_query <= in_data.now_ms;

      // ramp finished: settle at target, maybe turn back toward rest
      if (state == S_LEN && !before_start && !ramping) begin
        level_now <= target_level;
        if (resting_shown != target_shown) begin
          target_shown    <= resting_shown;
          level_at_change <= target_level;
          time_at_change  <= now_r;
        end else begin
          done_flag <= 1'b1;
        end
      end

      if (state == S_APPLY) level_now <= level_ramp;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_accept && fade_query) begin
      fade_in <= target_shown;
      now_r   <= in_data.now_ms;
      start_r <= start_calc;
      dur_r   <= target_shown ? in_duration_ms : out_duration_ms;
      dist_r  <= target_shown ? LEVEL_ONE - level_at_change : level_at_change;
    end

    case (state)
      S_START: begin
        prod_r <= mul_p;
        if (before_start) alpha_r <= fade_in ? '0 : LEVEL_ONE;
      end
      S_LEN: begin
        len_r     <= len_calc;
        elapsed_r <= elapsed_full[LEN_W-1:0];
        if (!ramping) alpha_r <= target_level;
      end
      S_MUL: begin
        prod_r  <= mul_p;
        rem_r   <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem_r   <= div_bit ? LEN_W'(div_trial - {1'b0, len_r}) : div_trial[LEN_W-1:0];
        prod_r  <= {prod_r[PROD_W-2:0], div_bit};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      S_APPLY: alpha_r <= level_ramp;
      default: ;
    endcase

    if (out_load_idle) begin
      out_data <= imm_item;
    end else if (out_load_seq) begin
      out_data.alpha            <= alpha_r;
      out_data.target_is_shown  <= target_shown;
      out_data.resting_is_shown <= resting_shown;
      out_data.will_toggle_back <= target_shown != resting_shown;
      out_data.fade_complete    <= done_flag;
    end
  end

  `AFE_ASSERT_NOW(a_level_in_range, clk, rst, 1'b1, level_now <= LEVEL_ONE)
  `AFE_ASSERT_NEXT(a_ramp_query_starts, clk, rst, in_accept && fade_query, state == S_START)
  `AFE_ASSERT_NOW(a_div_count_range, clk, rst, state == S_DIV,
                  div_cnt < DIV_CNT_W'(PROD_W))
  `AFE_ASSERT_NEXT(a_result_waits, clk, rst, state == S_OUT && out_valid && out_stall,
                   state == S_OUT)
  `AFE_ASSERT_NOW(a_busy_stalls, clk, rst, state != S_IDLE, in_stall)

endmodule
